FILE: hw/rtl/rcsl_pkg.sv
// ----------------------------------------------------------------------------
// RC channel signal-loss handler package
// Shared constants, codes and beat types of the channel failsafe block.
// ----------------------------------------------------------------------------
package rcsl_pkg;

  localparam int NUM_CHANNELS = 18;
  localparam int AVG_CHANNELS = 8;
  localparam int AVG_DEPTH    = 3;

  localparam int CHAN_W    = 5;
  localparam int PULSE_W   = 12;
  localparam int TIME_W    = 32;
  localparam int HOLD_W    = 16;
  localparam int FS_W      = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;

  localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int AVG_IDX_W = (AVG_CHANNELS > 1) ? $clog2(AVG_CHANNELS) : 1;
  localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

  localparam int SUM_W   = PULSE_W + $clog2(AVG_DEPTH);
  localparam int DIV_SH  = SUM_W;
  localparam int RECIP_W = DIV_SH + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'((2 ** DIV_SH) / AVG_DEPTH);

  localparam int FS_CHANNELS = 18;
  localparam int FS_BYTES    = 6;
  localparam int STICK_CHANNELS = 4;
  localparam int CH_YAW      = 2;
  localparam int CH_THROTTLE = 3;

  localparam logic [STICK_CHANNELS-1:0] STICK_MASK = 4'hF;
  localparam logic [PULSE_W-1:0] STEP_BASE = 12'd750;
  localparam logic [PULSE_W-1:0] STEP_SIZE = 12'd25;

  localparam logic [PULSE_W-1:0] RST_PULSE_MIN = 12'd885;
  localparam logic [PULSE_W-1:0] RST_PULSE_MAX = 12'd2115;
  localparam logic [PULSE_W-1:0] RST_CENTER    = 12'd1500;
  localparam logic [HOLD_W-1:0]  RST_HOLD_TIME = 16'd300;
  localparam logic [TIME_W-1:0]  RST_DEADLINE  = 32'd300;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_MIN = 3'd0,
    CFG_PULSE_MAX = 3'd1,
    CFG_CENTER    = 3'd2,
    CFG_AVG_EN    = 3'd3,
    CFG_HOLD_TIME = 3'd4,
    CFG_FS_A      = 3'd5,
    CFG_FS_B      = 3'd6,
    CFG_FS_C      = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FS_AUTO = 2'd0,
    FS_HOLD = 2'd1,
    FS_SET  = 2'd2
  } fs_mode_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EVAL,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_min_us;
    logic [PULSE_W-1:0] pulse_max_us;
    logic [PULSE_W-1:0] center_value;
    logic               averaging_enable;
    logic [HOLD_W-1:0]  hold_time_ms;
    logic [FS_W-1:0]    failsafe_group_a;
    logic [FS_W-1:0]    failsafe_group_b;
    logic [FS_W-1:0]    failsafe_group_c;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan_index;
    logic [PULSE_W-1:0] pulse_width;
    logic [TIME_W-1:0]  now_ms;
    logic               link_good;
    logic               frame_first;
    logic               frame_last;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  out_channel;
    logic [PULSE_W-1:0] out_value;
    logic               pulse_ok;
    logic               flight_ok;
  } out_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [PULSE_W-1:0] sample;
    logic [TIME_W-1:0]  now;
    logic               ok;
    logic               in_range;
    logic               first;
    logic               last;
  } q_entry_t;

endpackage

FILE: hw/rtl/rcsl_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts input beats and classifies each pulse against the valid window.
// ----------------------------------------------------------------------------
module rcsl_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rcsl_pkg::in_item_t in_data_i,
  input  rcsl_pkg::cfg_t    cfg_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output rcsl_pkg::q_entry_t push_data_o
);
  import rcsl_pkg::*;

  logic [PULSE_W-1:0] sample;
  logic               in_range;

  assign sample   = in_data_i.link_good ? in_data_i.pulse_width : '0;
  assign in_range = {1'b0, in_data_i.chan_index} < (CHAN_W + 1)'(NUM_CHANNELS);

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  always_comb begin
    push_data_o.chan     = in_data_i.chan_index;
    push_data_o.sample   = sample;
    push_data_o.now      = in_data_i.now_ms;
    push_data_o.ok       = in_range && (sample >= cfg_i.pulse_min_us) &&
                           (sample <= cfg_i.pulse_max_us);
    push_data_o.in_range = in_range;
    push_data_o.first    = in_data_i.frame_first;
    push_data_o.last     = in_data_i.frame_last;
  end

endmodule

FILE: hw/rtl/rcsl_queue.sv
// ----------------------------------------------------------------------------
// Decoupling queue
// Short register queue of classified beats between front and back end.
// ----------------------------------------------------------------------------
module rcsl_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  rcsl_pkg::q_entry_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output rcsl_pkg::q_entry_t pop_data_o
);
  import rcsl_pkg::*;

  q_entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign push_ready_o = count_q != QCNT_W'(QDEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/rcsl_back.sv
// ----------------------------------------------------------------------------
// Back end
// Applies hold, failsafe and averaging per channel and drives the result beat.
// ----------------------------------------------------------------------------
module rcsl_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rcsl_pkg::cfg_t     cfg_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  rcsl_pkg::q_entry_t pop_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rcsl_pkg::out_item_t out_data_o
);
  import rcsl_pkg::*;

  back_state_e state_q, state_d;

  q_entry_t            cur_q;
  logic [PULSE_W-1:0]  held_q [NUM_CHANNELS];
  logic [TIME_W-1:0]   deadline_q [NUM_CHANNELS];
  logic [PULSE_W-1:0]  hist_q [AVG_CHANNELS][AVG_DEPTH];
  logic [SLOT_W-1:0]   slot_q;
  logic                warm_q;
  logic [STICK_CHANNELS-1:0] mask_q;

  logic [PULSE_W-1:0]  val_q;
  logic [SUM_W-1:0]    sum_q;
  logic [PROD_W-1:0]   prod_q;
  logic                fok_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic                out_free, pop, eval_en, mul_en, div_en, done_en;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [AVG_IDX_W-1:0] row_idx;
  logic [PULSE_W-1:0]  held_rd, fail_val, sample_ev, div_val;
  logic [TIME_W-1:0]   dl_rd;
  logic                in_hold, avg_on, go_avg, clear_bit;
  logic [7:0]          fs_bytes [FS_CHANNELS];
  logic [7:0]          fs_byte;
  logic [1:0]          fs_mode;
  logic [STICK_CHANNELS-1:0] mask_base, mask_new;
  logic [SUM_W-1:0]    sum;
  logic [PULSE_W-1:0]  q0;
  logic [SUM_W+3:0]    rem;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_ready_o = (state_q == BK_IDLE) || ((state_q == BK_DONE) && out_free);
  assign pop         = pop_valid_i && pop_ready_o;

  assign ch_idx  = cur_q.chan[CH_IDX_W-1:0];
  assign row_idx = ({1'b0, cur_q.chan} < (CHAN_W + 1)'(AVG_CHANNELS)) ?
                   cur_q.chan[AVG_IDX_W-1:0] : '0;
  assign held_rd = held_q[ch_idx];
  assign dl_rd   = deadline_q[ch_idx];
  assign in_hold = cur_q.now < dl_rd;

  always_comb begin
    for (int i = 0; i < FS_CHANNELS; i++) begin
      if (i < FS_BYTES) begin
        fs_bytes[i] = cfg_i.failsafe_group_a[i*8 +: 8];
      end else if (i < 2 * FS_BYTES) begin
        fs_bytes[i] = cfg_i.failsafe_group_b[(i-FS_BYTES)*8 +: 8];
      end else begin
        fs_bytes[i] = cfg_i.failsafe_group_c[(i-2*FS_BYTES)*8 +: 8];
      end
    end
  end

  always_comb begin
    if ({1'b0, cur_q.chan} < (CHAN_W + 1)'(FS_CHANNELS)) begin
      fs_byte = fs_bytes[cur_q.chan];
      fs_mode = fs_byte[1:0];
    end else begin
      fs_byte = '0;
      fs_mode = FS_HOLD;
    end
    case (fs_mode)
      FS_AUTO: begin
        if (cur_q.chan <= CHAN_W'(CH_YAW)) begin
          fail_val = cfg_i.center_value;
        end else if (cur_q.chan == CHAN_W'(CH_THROTTLE)) begin
          fail_val = cfg_i.pulse_min_us;
        end else begin
          fail_val = held_rd;
        end
      end
      FS_SET:  fail_val = STEP_BASE + STEP_SIZE * {6'd0, fs_byte[7:2]};
      default: fail_val = held_rd;
    endcase
  end

  assign sample_ev = cur_q.ok ? cur_q.sample : (in_hold ? held_rd : fail_val);
  assign mask_base = cur_q.first ? STICK_MASK : mask_q;
  assign clear_bit = cur_q.in_range && !cur_q.ok && !in_hold &&
                     (cur_q.chan < CHAN_W'(STICK_CHANNELS));
  assign mask_new  = clear_bit ? (mask_base & ~(STICK_CHANNELS'(1) << cur_q.chan[1:0]))
                               : mask_base;
  assign avg_on    = cfg_i.averaging_enable && cur_q.in_range &&
                     ({1'b0, cur_q.chan} < (CHAN_W + 1)'(AVG_CHANNELS));
  assign go_avg    = avg_on && warm_q;

  always_comb begin
    sum = '0;
    for (int k = 0; k < AVG_DEPTH; k++) begin
      if (slot_q == SLOT_W'(k)) begin
        sum = sum + SUM_W'(sample_ev);
      end else begin
        sum = sum + SUM_W'(hist_q[row_idx][k]);
      end
    end
  end

  assign q0  = prod_q[DIV_SH +: PULSE_W];
  assign rem = (SUM_W + 4)'(sum_q) - (SUM_W + 4)'(q0) * (SUM_W + 4)'(AVG_DEPTH);
  assign div_val = (rem >= (SUM_W + 4)'(AVG_DEPTH)) ? q0 + 1'b1 : q0;

  always_comb begin
    state_d = state_q;
    eval_en = 1'b0;
    mul_en  = 1'b0;
    div_en  = 1'b0;
    done_en = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (pop) begin
          state_d = BK_EVAL;
        end
      end
      BK_EVAL: begin
        eval_en = 1'b1;
        state_d = go_avg ? BK_MUL : BK_DONE;
      end
      BK_MUL: begin
        mul_en  = 1'b1;
        state_d = BK_DIV;
      end
      BK_DIV: begin
        div_en  = 1'b1;
        state_d = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) begin
          done_en = 1'b1;
          state_d = pop ? BK_EVAL : BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        held_q[i]     <= (i == CH_THROTTLE) ? RST_PULSE_MIN : RST_CENTER;
        deadline_q[i] <= RST_DEADLINE;
      end
      slot_q      <= '0;
      warm_q      <= 1'b0;
      mask_q      <= STICK_MASK;
      out_valid_q <= 1'b0;
    end else begin
      if (eval_en) begin
        mask_q <= mask_new;
        if (cur_q.in_range && cur_q.ok) begin
          deadline_q[ch_idx] <= cur_q.now + TIME_W'(cfg_i.hold_time_ms);
        end
        if (cur_q.last) begin
          if (slot_q == SLOT_W'(AVG_DEPTH - 1)) begin
            slot_q <= '0;
            warm_q <= 1'b1;
          end else begin
            slot_q <= slot_q + 1'b1;
          end
        end
      end
      if (done_en && cur_q.in_range) begin
        held_q[ch_idx] <= val_q;
      end
      if (done_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= pop_data_i;
    end
    if (eval_en) begin
      val_q <= cur_q.in_range ? sample_ev : '0;
      sum_q <= sum;
      fok_q <= mask_new == STICK_MASK;
      if (avg_on) begin
        hist_q[row_idx][slot_q] <= sample_ev;
      end
    end
    if (mul_en) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(AVG_RECIP);
    end
    if (div_en) begin
      val_q <= div_val;
    end
    if (done_en) begin
      out_q.out_channel <= cur_q.chan;
      out_q.out_value   <= val_q;
      out_q.pulse_ok    <= cur_q.ok;
      out_q.flight_ok   <= fok_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/rc_channel_signal_loss_handler.sv
// ----------------------------------------------------------------------------
// RC channel signal-loss handler
// Per-channel hold and failsafe of receiver pulses; three-frame averaging on channels 0-7.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Beat
// in       input      in_valid_i/in_ready_o   one channel pulse (in_item_t)
// out      output     out_valid_o/out_ready_i one channel result (out_item_t)
// cfg      input      cfg_valid_i/cfg_ready_o register index and write data
//
// A beat passes the back-end states EVAL and DONE, with MUL and DIV between them
// when its channel is averaged (the reciprocal multiply and its correction).
// A two-entry queue lets the front end take beats while a result waits.
// Reset is asynchronous and active low and loads the register defaults.
// Configuration writes are always taken in the cycle they are offered.
// ----------------------------------------------------------------------------
module rc_channel_signal_loss_handler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rcsl_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rcsl_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rcsl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rcsl_pkg::CFG_DAT_W-1:0]  cfg_data_i
);
  import rcsl_pkg::*;

  cfg_t     cfg_q;
  logic     push_valid, push_ready;
  q_entry_t push_data, pop_data;
  logic     pop_valid, pop_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_min_us     <= RST_PULSE_MIN;
      cfg_q.pulse_max_us     <= RST_PULSE_MAX;
      cfg_q.center_value     <= RST_CENTER;
      cfg_q.averaging_enable <= 1'b1;
      cfg_q.hold_time_ms     <= RST_HOLD_TIME;
      cfg_q.failsafe_group_a <= '0;
      cfg_q.failsafe_group_b <= '0;
      cfg_q.failsafe_group_c <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PULSE_MIN: cfg_q.pulse_min_us     <= cfg_data_i[PULSE_W-1:0];
        CFG_PULSE_MAX: cfg_q.pulse_max_us     <= cfg_data_i[PULSE_W-1:0];
        CFG_CENTER:    cfg_q.center_value     <= cfg_data_i[PULSE_W-1:0];
        CFG_AVG_EN:    cfg_q.averaging_enable <= cfg_data_i[0];
        CFG_HOLD_TIME: cfg_q.hold_time_ms     <= cfg_data_i[HOLD_W-1:0];
        CFG_FS_A:      cfg_q.failsafe_group_a <= cfg_data_i[FS_W-1:0];
        CFG_FS_B:      cfg_q.failsafe_group_b <= cfg_data_i[FS_W-1:0];
        CFG_FS_C:      cfg_q.failsafe_group_c <= cfg_data_i[FS_W-1:0];
        default:       cfg_q.center_value     <= cfg_q.center_value;
      endcase
    end
  end

  rcsl_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rcsl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rcsl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hw/rtl/rcsl_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Checks result beats and handshakes seen at the top-level ports.
// ----------------------------------------------------------------------------
module rcsl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input rcsl_pkg::in_item_t              in_data_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input rcsl_pkg::out_item_t             out_data_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [rcsl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [rcsl_pkg::CFG_DAT_W-1:0]  cfg_data_i
);
  import rcsl_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ({1'b0, out_data_o.out_channel} >= (CHAN_W + 1)'(NUM_CHANNELS))
    |-> out_data_o.out_value == '0 && !out_data_o.pulse_ok)
    else $error("unknown channel produced a value or a good pulse");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind rc_channel_signal_loss_handler rcsl_checker u_rcsl_checker (.*);
